// ===== hw/rtl/max_bipartite_matching_macros.svh =====
// Assertion macros used by the bipartite matching core.
`ifndef MAX_BIPARTITE_MATCHING_MACROS_SVH
`define MAX_BIPARTITE_MATCHING_MACROS_SVH
`ifndef SYNTHESIS
`define MBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/mbm_pkg.sv =====
// Types and constants of the bipartite matching block.
`timescale 1ns / 1ps
`default_nettype none
package mbm_pkg;
    localparam int FIELD_W = 11;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LEFT_COUNT  = 1'b0;
    localparam t_cfg_idx CFG_RIGHT_COUNT = 1'b1;

    typedef logic [1:0] t_err;
    localparam t_err ERR_NONE     = 2'd0;
    localparam t_err ERR_OVERFLOW = 2'd1;
    localparam t_err ERR_RANGE    = 2'd2;

    typedef struct packed {
        logic               has_edge;
        logic [FIELD_W-1:0] left_node;
        logic [FIELD_W-1:0] right_node;
        logic               last_edge;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] matching_size;
        t_err               error_code;
    } t_out_item;
endpackage
`default_nettype wire

// ===== hw/rtl/max_bipartite_matching.sv =====
// Top level of the bipartite matching block: configuration and result register.
`timescale 1ns / 1ps
`default_nettype none
// Each stored edge reads and then rewrites the head of its left node's adjacency list, and
// no new beat is taken until that write is done. The beat marked last starts the matching
// run, whose length depends on the graph: each Hopcroft-Karp phase visits edges in the
// layering search and again in the augmenting search, all through the registered-read
// memory ports of the node and edge stores. After reset and after each result the node
// stores are swept over max(MAX_LEFT + 1, MAX_RIGHT) addresses, during which no input beat
// is taken; configuration writes are taken at any time.
module max_bipartite_matching #(
    parameter int MAX_LEFT  = 1024,
    parameter int MAX_RIGHT = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire mbm_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [10:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mbm_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mbm_pkg::t_out_item      o_out_item
);
    import mbm_pkg::*;

    logic [10:0] r_left_count;
    logic [10:0] r_right_count;
    logic r_o_valid;
    t_out_item r_o_item;
    logic res_valid;
    t_out_item res;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= 11'd1;
            r_right_count <= 11'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEFT_COUNT: begin
                    r_left_count <= i_cfg_data;
                end
                CFG_RIGHT_COUNT: begin
                    r_right_count <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_valid) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_o_item <= res;
        end
    end

    mbm_core #(
        .MAX_LEFT(MAX_LEFT),
        .MAX_RIGHT(MAX_RIGHT),
        .MAX_EDGES(MAX_EDGES)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_left_count(r_left_count),
        .i_right_count(r_right_count),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_res_valid(res_valid),
        .o_res(res),
        .i_res_busy(r_o_valid)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/mbm_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mbm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mbm_core.sv =====
// Edge store, layering search and augmenting search sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "max_bipartite_matching_macros.svh"
module mbm_core #(
    parameter int MAX_LEFT  = 1024,
    parameter int MAX_RIGHT = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [10:0]         i_left_count,
    input  wire logic [10:0]         i_right_count,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mbm_pkg::t_in_item   i_in_item,
    output logic                     o_res_valid,
    output mbm_pkg::t_out_item       o_res,
    input  wire logic                i_res_busy
);
    import mbm_pkg::*;

    localparam int NW = $clog2(MAX_LEFT + 1);
    localparam int DW = $clog2(MAX_LEFT + 2);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int QA = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
    localparam int RA = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CLR_N = (MAX_LEFT + 1 > MAX_RIGHT) ? MAX_LEFT + 1 : MAX_RIGHT;
    localparam int CW = $clog2(CLR_N + 1);
    localparam int SW = NW + EW + DW;
    localparam int XW = RA + EW;
    localparam logic [EW-1:0] EMPTY = EW'(MAX_EDGES);
    localparam logic [DW-1:0] DIST_INF = DW'(MAX_LEFT + 1);

    typedef enum logic [29:0] {
        S_CLEAR    = 30'd1 << 0,
        S_IDLE     = 30'd1 << 1,
        S_LOAD_WR  = 30'd1 << 2,
        S_START    = 30'd1 << 3,
        S_LI_RD    = 30'd1 << 4,
        S_LI_WR    = 30'd1 << 5,
        S_LI_END   = 30'd1 << 6,
        S_BFS_POP  = 30'd1 << 7,
        S_BFS_U    = 30'd1 << 8,
        S_BFS_E0   = 30'd1 << 9,
        S_BFS_E    = 30'd1 << 10,
        S_BFS_R    = 30'd1 << 11,
        S_BFS_W    = 30'd1 << 12,
        S_BFS_D    = 30'd1 << 13,
        S_BFS_END  = 30'd1 << 14,
        S_BFS_CHK  = 30'd1 << 15,
        S_AS_RD    = 30'd1 << 16,
        S_AS_CHK   = 30'd1 << 17,
        S_AUG_HEAD = 30'd1 << 18,
        S_AUG_TOP  = 30'd1 << 19,
        S_AUG_POP  = 30'd1 << 20,
        S_AUG_ADV  = 30'd1 << 21,
        S_AUG_R    = 30'd1 << 22,
        S_AUG_W    = 30'd1 << 23,
        S_AUG_D    = 30'd1 << 24,
        S_AUG_FIX  = 30'd1 << 25,
        S_FIX_RD   = 30'd1 << 26,
        S_FIX_E    = 30'd1 << 27,
        S_FIX_W    = 30'd1 << 28,
        S_DONE     = 30'd1 << 29
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_ci, n_ci;
    logic [EW-1:0] r_stored, n_stored;
    t_err r_err, n_err;
    logic [QA-1:0] r_a_idx, n_a_idx;
    logic [RA-1:0] r_b, n_b;
    logic r_last, n_last;
    logic [NW-1:0] r_n, n_n;
    logic [NW-1:0] r_total, n_total;
    logic [DW-1:0] r_idx, n_idx;
    logic [NW-1:0] r_qhead, n_qhead;
    logic [NW-1:0] r_qtail, n_qtail;
    logic [NW-1:0] r_u, n_u;
    logic [EW-1:0] r_e, n_e;
    logic [EW-1:0] r_enext, n_enext;
    logic [DW-1:0] r_du, n_du;
    logic [RA-1:0] r_v, n_v;
    logic [NW-1:0] r_w, n_w;
    logic [NW-1:0] r_depth, n_depth;
    logic [NW-1:0] r_k, n_k;
    logic [NW-1:0] r_fu, n_fu;
    t_out_item r_res, n_res;

    logic head_we, edge_we, lmat_we, rp_we, dist_we, q_we, stk_we;
    logic [QA-1:0] head_wa, head_ra, q_wa, q_ra, stk_wa, stk_ra;
    logic [EA-1:0] edge_wa, edge_ra;
    logic [NW-1:0] lmat_wa, lmat_ra, dist_wa, dist_ra;
    logic [RA-1:0] rp_wa, rp_ra;
    logic [EW-1:0] head_wd, head_rd;
    logic [XW-1:0] edge_wd, edge_rd;
    logic lmat_wd, lmat_rd;
    logic [NW-1:0] rp_wd, rp_rd, q_wd, q_rd;
    logic [DW-1:0] dist_wd, dist_rd;
    logic [SW-1:0] stk_wd, stk_rd;

    logic [31:0] n_use, m_use;
    logic range_bad, store_full;
    logic [RA-1:0] edge_tgt;
    logic [EW-1:0] edge_lnk;
    logic [NW-1:0] stk_node;
    logic [EW-1:0] stk_edge;
    logic [DW-1:0] stk_du;

    mbm_ram #(.DEPTH(MAX_LEFT), .WIDTH(EW)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_rd));
    mbm_ram #(.DEPTH(MAX_EDGES), .WIDTH(XW)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_wa), .i_wdata(edge_wd),
        .i_raddr(edge_ra), .o_rdata(edge_rd));
    mbm_ram #(.DEPTH(MAX_LEFT + 1), .WIDTH(1)) u_lmat (
        .i_clk(i_clk), .i_we(lmat_we), .i_waddr(lmat_wa), .i_wdata(lmat_wd),
        .i_raddr(lmat_ra), .o_rdata(lmat_rd));
    mbm_ram #(.DEPTH(MAX_RIGHT), .WIDTH(NW)) u_rpart (
        .i_clk(i_clk), .i_we(rp_we), .i_waddr(rp_wa), .i_wdata(rp_wd),
        .i_raddr(rp_ra), .o_rdata(rp_rd));
    mbm_ram #(.DEPTH(MAX_LEFT + 1), .WIDTH(DW)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_wa), .i_wdata(dist_wd),
        .i_raddr(dist_ra), .o_rdata(dist_rd));
    mbm_ram #(.DEPTH(MAX_LEFT), .WIDTH(NW)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rd));
    mbm_ram #(.DEPTH(MAX_LEFT), .WIDTH(SW)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    assign edge_tgt = edge_rd[XW-1 -: RA];
    assign edge_lnk = edge_rd[EW-1:0];
    assign stk_node = stk_rd[SW-1 -: NW];
    assign stk_edge = stk_rd[DW+EW-1 -: EW];
    assign stk_du   = stk_rd[DW-1:0];

    assign n_use = (32'(i_left_count) < MAX_LEFT) ? 32'(i_left_count) : 32'(MAX_LEFT);
    assign m_use = (32'(i_right_count) < MAX_RIGHT) ? 32'(i_right_count) : 32'(MAX_RIGHT);
    assign range_bad = (i_in_item.left_node == '0) || (32'(i_in_item.left_node) > n_use)
        || (i_in_item.right_node == '0) || (32'(i_in_item.right_node) > m_use);
    assign store_full = 32'(r_stored) >= MAX_EDGES;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE) && !i_res_busy;
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;  n_ci = r_ci;       n_stored = r_stored; n_err = r_err;
        n_a_idx = r_a_idx;  n_b = r_b;         n_last = r_last;     n_n = r_n;
        n_total = r_total;  n_idx = r_idx;     n_qhead = r_qhead;   n_qtail = r_qtail;
        n_u = r_u;          n_e = r_e;         n_enext = r_enext;   n_du = r_du;
        n_v = r_v;          n_w = r_w;         n_depth = r_depth;   n_k = r_k;
        n_fu = r_fu;        n_res = r_res;
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
        edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
        lmat_we = 1'b0; lmat_wa = '0; lmat_wd = 1'b0; lmat_ra = '0;
        rp_we = 1'b0;   rp_wa = '0;   rp_wd = '0;   rp_ra = '0;
        dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
        q_we = 1'b0;    q_wa = '0;    q_wd = '0;    q_ra = '0;
        stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;  stk_ra = '0;
        case (r_state)
            S_CLEAR: begin
                head_we = 32'(r_ci) < MAX_LEFT;
                head_wa = QA'(r_ci);
                head_wd = EMPTY;
                lmat_we = 32'(r_ci) <= MAX_LEFT;
                lmat_wa = NW'(r_ci);
                rp_we   = 32'(r_ci) < MAX_RIGHT;
                rp_wa   = RA'(r_ci);
                n_ci = r_ci + CW'(1);
                if (32'(r_ci) == CLR_N - 1) begin
                    n_stored = '0;
                    n_err = ERR_NONE;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_in_item.last_edge;
                    if (i_in_item.has_edge && !range_bad && !store_full) begin
                        head_ra = QA'(i_in_item.left_node - FIELD_W'(1));
                        n_a_idx = QA'(i_in_item.left_node - FIELD_W'(1));
                        n_b = RA'(i_in_item.right_node - FIELD_W'(1));
                        n_state = S_LOAD_WR;
                    end else begin
                        if (i_in_item.has_edge && r_err == ERR_NONE) begin
                            n_err = range_bad ? ERR_RANGE : ERR_OVERFLOW;
                        end
                        if (i_in_item.last_edge) begin
                            n_state = S_START;
                        end
                    end
                end
            end
            S_LOAD_WR: begin
                head_we = 1'b1;
                head_wa = r_a_idx;
                head_wd = r_stored;
                edge_we = 1'b1;
                edge_wa = EA'(r_stored);
                edge_wd = {r_b, head_rd};
                n_stored = r_stored + EW'(1);
                n_state = r_last ? S_START : S_IDLE;
            end
            S_START: begin
                n_n = NW'(n_use);
                if (r_err != ERR_NONE) begin
                    n_res = '{matching_size: '0, error_code: r_err};
                    n_state = S_DONE;
                end else begin
                    n_total = '0;
                    n_idx = DW'(1);
                    n_qhead = '0;
                    n_qtail = '0;
                    n_state = S_LI_RD;
                end
            end
            S_LI_RD: begin
                if (r_idx > DW'(r_n)) begin
                    n_state = S_LI_END;
                end else begin
                    lmat_ra = NW'(r_idx);
                    n_state = S_LI_WR;
                end
            end
            S_LI_WR: begin
                dist_we = 1'b1;
                dist_wa = NW'(r_idx);
                if (!lmat_rd) begin
                    dist_wd = '0;
                    q_we = 1'b1;
                    q_wa = QA'(r_qtail);
                    q_wd = NW'(r_idx);
                    n_qtail = r_qtail + NW'(1);
                end else begin
                    dist_wd = DIST_INF;
                end
                n_idx = r_idx + DW'(1);
                n_state = S_LI_RD;
            end
            S_LI_END: begin
                dist_we = 1'b1;
                dist_wa = '0;
                dist_wd = DIST_INF;
                n_state = S_BFS_POP;
            end
            S_BFS_POP: begin
                if (r_qhead < r_qtail) begin
                    q_ra = QA'(r_qhead);
                    n_state = S_BFS_U;
                end else begin
                    n_state = S_BFS_END;
                end
            end
            S_BFS_U: begin
                n_u = q_rd;
                n_qhead = r_qhead + NW'(1);
                head_ra = QA'(q_rd - NW'(1));
                dist_ra = q_rd;
                n_state = S_BFS_E0;
            end
            S_BFS_E0: begin
                n_e = head_rd;
                n_du = dist_rd;
                n_state = S_BFS_E;
            end
            S_BFS_E: begin
                if (r_e == EMPTY) begin
                    n_state = S_BFS_POP;
                end else begin
                    edge_ra = EA'(r_e);
                    n_state = S_BFS_R;
                end
            end
            S_BFS_R: begin
                n_enext = edge_lnk;
                rp_ra = edge_tgt;
                n_state = S_BFS_W;
            end
            S_BFS_W: begin
                n_w = rp_rd;
                dist_ra = rp_rd;
                n_state = S_BFS_D;
            end
            S_BFS_D: begin
                if (dist_rd == DIST_INF) begin
                    dist_we = 1'b1;
                    dist_wa = r_w;
                    dist_wd = r_du + DW'(1);
                    if (r_w != '0 && 32'(r_qtail) < MAX_LEFT) begin
                        q_we = 1'b1;
                        q_wa = QA'(r_qtail);
                        q_wd = r_w;
                        n_qtail = r_qtail + NW'(1);
                    end
                end
                n_e = r_enext;
                n_state = S_BFS_E;
            end
            S_BFS_END: begin
                dist_ra = '0;
                n_state = S_BFS_CHK;
            end
            S_BFS_CHK: begin
                if (dist_rd == DIST_INF) begin
                    n_res = '{matching_size: FIELD_W'(r_total), error_code: ERR_NONE};
                    n_state = S_DONE;
                end else begin
                    n_idx = DW'(1);
                    n_state = S_AS_RD;
                end
            end
            S_AS_RD: begin
                if (r_idx > DW'(r_n)) begin
                    n_idx = DW'(1);
                    n_qhead = '0;
                    n_qtail = '0;
                    n_state = S_LI_RD;
                end else begin
                    lmat_ra = NW'(r_idx);
                    n_state = S_AS_CHK;
                end
            end
            S_AS_CHK: begin
                if (lmat_rd) begin
                    n_idx = r_idx + DW'(1);
                    n_state = S_AS_RD;
                end else begin
                    n_u = NW'(r_idx);
                    n_depth = NW'(1);
                    head_ra = QA'(r_idx - DW'(1));
                    dist_ra = NW'(r_idx);
                    n_state = S_AUG_HEAD;
                end
            end
            S_AUG_HEAD: begin
                n_e = head_rd;
                n_du = dist_rd;
                n_state = S_AUG_TOP;
            end
            S_AUG_TOP: begin
                if (r_e == EMPTY) begin
                    dist_we = 1'b1;
                    dist_wa = r_u;
                    dist_wd = DIST_INF;
                    n_depth = r_depth - NW'(1);
                    if (r_depth == NW'(1)) begin
                        n_idx = r_idx + DW'(1);
                        n_state = S_AS_RD;
                    end else begin
                        stk_ra = QA'(r_depth - NW'(2));
                        n_state = S_AUG_POP;
                    end
                end else begin
                    edge_ra = EA'(r_e);
                    n_state = S_AUG_R;
                end
            end
            S_AUG_POP: begin
                n_u = stk_node;
                n_du = stk_du;
                edge_ra = EA'(stk_edge);
                n_state = S_AUG_ADV;
            end
            S_AUG_ADV: begin
                n_e = edge_lnk;
                n_state = S_AUG_TOP;
            end
            S_AUG_R: begin
                n_v = edge_tgt;
                n_enext = edge_lnk;
                rp_ra = edge_tgt;
                n_state = S_AUG_W;
            end
            S_AUG_W: begin
                n_w = rp_rd;
                dist_ra = rp_rd;
                n_state = S_AUG_D;
            end
            S_AUG_D: begin
                n_e = r_enext;
                n_state = S_AUG_TOP;
                if ({1'b0, dist_rd} == {1'b0, r_du} + (DW + 1)'(1)) begin
                    if (r_w == '0) begin
                        n_e = r_e;
                        n_state = S_AUG_FIX;
                    end else if (32'(r_depth) < MAX_LEFT) begin
                        stk_we = 1'b1;
                        stk_wa = QA'(r_depth - NW'(1));
                        stk_wd = {r_u, r_e, r_du};
                        n_u = r_w;
                        n_depth = r_depth + NW'(1);
                        head_ra = QA'(r_w - NW'(1));
                        dist_ra = r_w;
                        n_e = r_e;
                        n_state = S_AUG_HEAD;
                    end
                end
            end
            S_AUG_FIX: begin
                lmat_we = 1'b1;
                lmat_wa = r_u;
                lmat_wd = 1'b1;
                rp_we = 1'b1;
                rp_wa = r_v;
                rp_wd = r_u;
                n_k = '0;
                n_state = S_FIX_RD;
            end
            S_FIX_RD: begin
                if (r_k == r_depth - NW'(1)) begin
                    n_total = r_total + NW'(1);
                    n_idx = r_idx + DW'(1);
                    n_state = S_AS_RD;
                end else begin
                    stk_ra = QA'(r_k);
                    n_state = S_FIX_E;
                end
            end
            S_FIX_E: begin
                n_fu = stk_node;
                edge_ra = EA'(stk_edge);
                n_state = S_FIX_W;
            end
            S_FIX_W: begin
                lmat_we = 1'b1;
                lmat_wa = r_fu;
                lmat_wd = 1'b1;
                rp_we = 1'b1;
                rp_wa = edge_tgt;
                rp_wd = r_fu;
                n_k = r_k + NW'(1);
                n_state = S_FIX_RD;
            end
            S_DONE: begin
                if (!i_res_busy) begin
                    n_ci = '0;
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_ci = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ci     <= '0;
            r_stored <= '0;
            r_err    <= ERR_NONE;
            r_qhead  <= '0;
            r_qtail  <= '0;
            r_depth  <= '0;
        end else begin
            r_state  <= n_state;
            r_ci     <= n_ci;
            r_stored <= n_stored;
            r_err    <= n_err;
            r_qhead  <= n_qhead;
            r_qtail  <= n_qtail;
            r_depth  <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= n_a_idx;
        r_b     <= n_b;
        r_last  <= n_last;
        r_n     <= n_n;
        r_total <= n_total;
        r_idx   <= n_idx;
        r_u     <= n_u;
        r_e     <= n_e;
        r_enext <= n_enext;
        r_du    <= n_du;
        r_v     <= n_v;
        r_w     <= n_w;
        r_k     <= n_k;
        r_fu    <= n_fu;
        r_res   <= n_res;
    end

    `MBM_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, 32'(r_depth) <= MAX_LEFT)
    `MBM_ASSERT_IMP(a_queue_order, i_clk, i_rst_n, r_state == S_BFS_POP, r_qhead <= r_qtail)
    `MBM_ASSERT_NXT(a_store_grows, i_clk, i_rst_n, r_state == S_LOAD_WR,
        r_stored == $past(r_stored) + EW'(1))
endmodule
`default_nettype wire

// ===== tb/mbm_checker.sv =====
// Checker for the bipartite matching block: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module mbm_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire mbm_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [10:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire mbm_pkg::t_in_item  i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire mbm_pkg::t_out_item i_out_item,
    output int                      o_fail_count,
    output int                      o_pending
);
    import mbm_pkg::*;

    localparam int NODE_LIMIT = 1024;
    localparam int EDGE_LIMIT = 4096;

    int        left_in_use;
    int        right_in_use;
    int        edge_total;
    t_err      held_error;
    int        adjacency [1:NODE_LIMIT][$];
    int        right_mate [1:NODE_LIMIT];
    bit        right_seen [1:NODE_LIMIT];
    t_out_item expected_results [$];

    task automatic report_mismatch(input string what);
        $display("%0t: MISMATCH %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic int clip_count(input logic [10:0] raw);
        return (raw > NODE_LIMIT) ? NODE_LIMIT : int'(raw);
    endfunction

    function automatic bit find_augmenting(input int u);
        int v;
        for (int k = 0; k < adjacency[u].size(); k++) begin
            v = adjacency[u][k];
            if (!right_seen[v]) begin
                right_seen[v] = 1'b1;
                if (right_mate[v] == 0 || find_augmenting(right_mate[v])) begin
                    right_mate[v] = u;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic int count_matching(input int n);
        int total;
        total = 0;
        for (int v = 1; v <= NODE_LIMIT; v++) right_mate[v] = 0;
        for (int u = 1; u <= n; u++) begin
            for (int v = 1; v <= NODE_LIMIT; v++) right_seen[v] = 1'b0;
            if (find_augmenting(u)) total++;
        end
        return total;
    endfunction

    task automatic clear_graph();
        for (int u = 1; u <= NODE_LIMIT; u++) adjacency[u].delete();
        edge_total = 0;
        held_error = ERR_NONE;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_err      code;
        int        a;
        int        b;
        if (!i_rst_n) begin
            left_in_use  = 1;
            right_in_use = 1;
            clear_graph();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with no expectation waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.matching_size !== want.matching_size)
                        report_mismatch($sformatf("matching_size got %0d want %0d",
                            i_out_item.matching_size, want.matching_size));
                    if (i_out_item.error_code !== want.error_code)
                        report_mismatch($sformatf("error_code got %0d want %0d",
                            i_out_item.error_code, want.error_code));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LEFT_COUNT) left_in_use = clip_count(i_cfg_data);
                else right_in_use = clip_count(i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.has_edge) begin
                    a = int'(i_in_item.left_node);
                    b = int'(i_in_item.right_node);
                    code = ERR_NONE;
                    if (a == 0 || a > left_in_use || b == 0 || b > right_in_use)
                        code = ERR_RANGE;
                    else if (edge_total >= EDGE_LIMIT)
                        code = ERR_OVERFLOW;
                    if (code != ERR_NONE) begin
                        if (held_error == ERR_NONE) held_error = code;
                    end else begin
                        adjacency[a] = {adjacency[a], b};
                        edge_total++;
                    end
                end
                if (i_in_item.last_edge) begin
                    want.error_code    = held_error;
                    want.matching_size = (held_error == ERR_NONE)
                        ? 11'(count_matching(left_in_use)) : '0;
                    expected_results = {expected_results, want};
                    clear_graph();
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule
`default_nettype wire

// ===== tb/tb_max_bipartite_matching.sv =====
// Top of the bipartite matching testbench: stimulus, reset, clock and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_max_bipartite_matching;
    import mbm_pkg::*;

    localparam int ITEM_TARGET = 700;
    localparam int CYCLE_LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    t_cfg_idx  cfg_index;
    logic [10:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        quiet;
    int        items_sent;
    int        cur_left;
    int        cur_right;

    max_bipartite_matching dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    mbm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("max_bipartite_matching test failed");
                $finish;
            end
        end
    end

    // The result side stalls in bursts until the quiet tail of the run.
    initial begin
        out_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                if ($urandom_range(0, 1)) begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 9)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_in_item make_item(input bit has_edge, input int a, input int b,
                                           input bit last);
        t_in_item item;
        item.has_edge   = has_edge;
        item.left_node  = 11'(a);
        item.right_node = 11'(b);
        item.last_edge  = last;
        return item;
    endfunction

    task automatic send_beat(input t_in_item item);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (in_stall);
        if (item.has_edge || item.last_edge) items_sent++;
    endtask

    task automatic send_edge(input int a, input int b, input bit last);
        send_beat(make_item(1'b1, a, b, last));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 11'(value);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_counts(input int n, input int m);
        wait_idle();
        write_reg(CFG_LEFT_COUNT, n);
        write_reg(CFG_RIGHT_COUNT, m);
        cur_left  = (n > 1024) ? 1024 : n;
        cur_right = (m > 1024) ? 1024 : m;
    endtask

    function automatic int pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 1024;
        if (sel == 1) return 1;
        if (sel == 2) return $urandom_range(1, 2047);
        return $urandom_range(2, 12);
    endfunction

    task automatic random_graph();
        int edges;
        int kind;
        edges = $urandom_range(0, 15);
        for (int k = 0; k < edges; k++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                send_beat(make_item(1'b0, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                    1'b0));
            else if (kind == 1)
                send_edge($urandom_range(0, 2047), $urandom_range(0, 2047), 1'b0);
            else
                send_edge($urandom_range(1, cur_left), $urandom_range(1, cur_right), 1'b0);
        end
        if ($urandom_range(0, 1))
            send_beat(make_item(1'b0, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                1'b1));
        else
            send_edge($urandom_range(1, cur_left), $urandom_range(1, cur_right), 1'b1);
    endtask

    initial begin
        quiet      = 1'b0;
        items_sent = 0;
        cur_left   = 1;
        cur_right  = 1;
        i_rst_n    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_LEFT_COUNT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_item    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_edge(1, 1, 1'b1);
        send_beat(make_item(1'b0, 0, 0, 1'b1));
        set_counts(3, 3);
        send_edge(1, 1, 1'b0);
        send_edge(1, 2, 1'b0);
        send_edge(2, 1, 1'b0);
        send_beat(make_item(1'b0, 2047, 2047, 1'b0));
        send_edge(3, 2, 1'b0);
        send_edge(2, 3, 1'b1);
        send_edge(0, 1, 1'b0);
        send_edge(1, 1, 1'b1);
        send_edge(1, 4, 1'b1);
        send_edge(1, 1, 1'b0);
        send_edge(2047, 1, 1'b1);
        // Loading goes on across a change of the left count.
        send_edge(3, 3, 1'b0);
        send_edge(1, 1, 1'b0);
        wait_idle();
        write_reg(CFG_LEFT_COUNT, 1);
        send_beat(make_item(1'b0, 0, 0, 1'b1));
        set_counts(1024, 1024);
        send_edge(1024, 1024, 1'b0);
        send_edge(1, 1024, 1'b0);
        send_edge(1024, 1, 1'b1);
        set_counts(1, 1);
        send_edge(1, 1, 1'b0);
        send_edge(0, 1, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET * 9 / 10) quiet = 1'b1;
            if ($urandom_range(0, 3) == 0) set_counts(pick_count(), pick_count());
            random_graph();
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("max_bipartite_matching test passed");
        else
            $display("max_bipartite_matching test failed");
        $finish;
    end
endmodule
`default_nettype wire
